// File: src/orientation_coverage_tracker_unit_macros.svh
// ---------------------------------------------------------------------------
// Orientation coverage tracker assertion macros
// Shared property shapes for the checks at the end of the top level.
// They expect clk and arst_n in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef ORIENTATION_COVERAGE_TRACKER_UNIT_MACROS_SVH
`define ORIENTATION_COVERAGE_TRACKER_UNIT_MACROS_SVH

// same-cycle implication
`define OCOV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OCOV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/ocov_pkg.sv
// ---------------------------------------------------------------------------
// ocov_pkg
// Types and constants shared by the orientation coverage tracker modules.
// ---------------------------------------------------------------------------
`default_nettype none

package ocov_pkg;

	localparam int BOUND_W = 15;
	localparam int DWELL_W = 16;
	localparam int PROG_W  = 8;
	localparam int SIDE_W  = 6;

	localparam int RUN_BIT   = 7;
	localparam int READY_BIT = 6;

	localparam logic [PROG_W-1:0]  ALL_SIDES_RUNNING = 8'hBF;

	localparam logic [BOUND_W-1:0] LOWER_RST = 15'd3277; // 0.8 g
	localparam logic [BOUND_W-1:0] UPPER_RST = 15'd4915; // 1.2 g
	localparam logic [DWELL_W-1:0] DWELL_RST = 16'd1000;

	// request codes
	typedef enum logic [1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_START  = 2'd1,
		REQ_ABORT  = 2'd2
	} req_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_LOWER = 2'd0,
		CFG_UPPER = 2'd1,
		CFG_DWELL = 2'd2
	} cfg_idx_t;

	// classified request as it sits in the queue
	typedef struct packed {
		logic [1:0]        req;
		logic [SIDE_W-1:0] sides;
	} cls_t;

	// queue status seen by both ends
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

`default_nettype wire

// File: src/ocov_if.sv
// ---------------------------------------------------------------------------
// ocov interfaces
// Valid/ready channels for requests in and progress results out.
// ---------------------------------------------------------------------------
`default_nettype none

interface ocov_in_if #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int TIME_WIDTH   = 32
) ();
	logic                           valid;
	logic                           ready;
	logic [1:0]                     req_type;
	logic signed [SAMPLE_WIDTH-1:0] accel_x;
	logic signed [SAMPLE_WIDTH-1:0] accel_y;
	logic signed [SAMPLE_WIDTH-1:0] accel_z;
	logic [TIME_WIDTH-1:0]          now_ms;

	modport source (output valid, req_type, accel_x, accel_y, accel_z, now_ms,
		input ready);
	modport sink (input valid, req_type, accel_x, accel_y, accel_z, now_ms,
		output ready);
endinterface

interface ocov_out_if ();
	logic       valid;
	logic       ready;
	logic [7:0] progress;
	logic       side_committed;
	logic       ready_res;

	modport source (output valid, progress, side_committed, ready_res, input ready);
	modport sink (input valid, progress, side_committed, ready_res, output ready);
endinterface

`default_nettype wire

// File: src/ocov_front.sv
// ---------------------------------------------------------------------------
// ocov_front
// Accepts requests and classifies each sample into the six side hits.
// ---------------------------------------------------------------------------
`default_nettype none

module ocov_front #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int TIME_WIDTH   = 32
) (
	ocov_in_if.sink                      item,
	input  logic [ocov_pkg::BOUND_W-1:0] lower_bound,
	input  logic [ocov_pkg::BOUND_W-1:0] upper_bound,
	input  ocov_pkg::fifo_stat_t         q_stat,
	output logic                         push,
	output ocov_pkg::cls_t               cls,
	output logic [TIME_WIDTH-1:0]        now
);
	import ocov_pkg::*;

	// compare width holds both the sample and the negated bounds
	localparam int CW = ((SAMPLE_WIDTH > BOUND_W) ? SAMPLE_WIDTH : BOUND_W) + 1;

	logic signed [CW-1:0] lo;
	logic signed [CW-1:0] hi;
	logic [1:0]           hit_x;
	logic [1:0]           hit_y;
	logic [1:0]           hit_z;

	// {plus, minus}: magnitude strictly inside (lo, hi)
	function automatic logic [1:0] axis_hit(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] l, input logic signed [CW-1:0] h);
		logic mn;
		logic pl;
		mn = (a < -l) && (a > -h);
		pl = (a > l) && (a < h);
		return {pl, mn};
	endfunction

	assign lo = signed'(CW'(lower_bound));
	assign hi = signed'(CW'(upper_bound));

	assign hit_x = axis_hit(CW'(item.accel_x), lo, hi);
	assign hit_y = axis_hit(CW'(item.accel_y), lo, hi);
	assign hit_z = axis_hit(CW'(item.accel_z), lo, hi);

	// take a request whenever the queue has room
	assign item.ready = !q_stat.full;
	assign push       = item.valid && !q_stat.full;
	assign cls.req    = item.req_type;
	assign cls.sides  = {hit_z, hit_y, hit_x};
	assign now        = item.now_ms;

endmodule

`default_nettype wire

// File: src/ocov_fifo.sv
// ---------------------------------------------------------------------------
// ocov_fifo
// Two-entry queue between the classifier and the state update.
// ---------------------------------------------------------------------------
`default_nettype none

module ocov_fifo #(
	parameter int WIDTH = 40
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 pop,
	output logic [WIDTH-1:0]     rdata,
	output ocov_pkg::fifo_stat_t stat
);
	import ocov_pkg::*;

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign rdata      = mem_q[rd_ptr_q];
	assign stat.full  = cnt_q[1];
	assign stat.empty = (cnt_q == 2'd0);

endmodule

`default_nettype wire

// File: src/ocov_back.sv
// ---------------------------------------------------------------------------
// ocov_back
// Applies queued requests to the coverage state and registers the result.
// ---------------------------------------------------------------------------
`default_nettype none

module ocov_back #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ocov_pkg::fifo_stat_t         q_stat,
	input  ocov_pkg::cls_t               cls,
	input  logic [TIME_WIDTH-1:0]        now,
	input  logic [ocov_pkg::DWELL_W-1:0] dwell_ms,
	output logic                         pop,
	ocov_out_if.source                   result
);
	import ocov_pkg::*;

	logic [PROG_W-1:0]     prog_q;
	logic [PROG_W-1:0]     cand_q;
	logic [TIME_WIDTH-1:0] dl_q;

	logic [PROG_W-1:0]     nxt_prog;
	logic [PROG_W-1:0]     nxt_cand;
	logic [TIME_WIDTH-1:0] nxt_dl;
	logic                  commit;
	logic [PROG_W-1:0]     grown;
	logic [TIME_WIDTH-1:0] diff;
	logic                  after;

	logic                  ovalid_q;
	logic [PROG_W-1:0]     oprog_q;
	logic                  ocommit_q;

	assign grown = prog_q | PROG_W'(cls.sides);
	assign diff  = now - dl_q;
	assign after = (diff != '0) && !diff[TIME_WIDTH-1];

	// next coverage state for the request at the queue head
	always_comb begin
		nxt_prog = prog_q;
		nxt_cand = cand_q;
		nxt_dl   = dl_q;
		commit   = 1'b0;
		unique case (cls.req)
			REQ_START: begin
				if (!prog_q[RUN_BIT]) begin
					nxt_prog = '0;
					nxt_cand = '0;
					nxt_dl   = '0;
				end
				nxt_prog[RUN_BIT] = 1'b1;
			end
			REQ_ABORT: begin
				nxt_prog = '0;
				nxt_cand = '0;
				nxt_dl   = '0;
			end
			REQ_SAMPLE: begin
				if (prog_q[RUN_BIT]) begin
					if (grown != prog_q && grown == cand_q) begin
						if (after) begin
							nxt_prog = grown;
							commit   = 1'b1;
						end
					end else begin
						nxt_dl   = now + TIME_WIDTH'(dwell_ms);
						nxt_cand = grown;
					end
					if (nxt_prog == ALL_SIDES_RUNNING) begin
						nxt_prog[READY_BIT] = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// one request per cycle while the queue is not empty and the output register is free or draining
	assign pop = !q_stat.empty && (!ovalid_q || result.ready);

	// coverage state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_q <= '0;
			cand_q <= '0;
			dl_q   <= '0;
		end else if (pop) begin
			prog_q <= nxt_prog;
			cand_q <= nxt_cand;
			dl_q   <= nxt_dl;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else begin
			ovalid_q <= pop || (ovalid_q && !result.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			oprog_q   <= nxt_prog;
			ocommit_q <= commit;
		end
	end

	assign result.valid          = ovalid_q;
	assign result.progress       = oprog_q;
	assign result.side_committed = ocommit_q;
	assign result.ready_res      = oprog_q[READY_BIT];

endmodule

`default_nettype wire

// File: src/orientation_coverage_tracker_unit.sv
// ---------------------------------------------------------------------------
// orientation_coverage_tracker_unit
// Tracks which of the six accelerometer orientations have been held long
// enough during a calibration run, and raises ready once all are seen.
// ---------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  item      in   item.valid/ready       req_type, accel_x/y/z, now_ms
//  result    out  result.valid/ready     progress, side_committed, ready_res
//  cfg       in   cfg_we (no stall)      cfg_index, cfg_wdata
//
// One request per cycle while the queue has room; each request is classified
// and written into the queue when it is taken, and the state update loads the
// output register when it pops that request from the queue. The two-entry queue
// lets intake continue while a result waits on result.ready; item.ready drops
// once both entries are filled. Reset clears state, queue and output valid and
// loads the default bounds and dwell time; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

`include "orientation_coverage_tracker_unit_macros.svh"

module orientation_coverage_tracker_unit #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int TIME_WIDTH   = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [ocov_pkg::DWELL_W-1:0] cfg_wdata,
	ocov_in_if.sink                      item,
	ocov_out_if.source                   result
);
	import ocov_pkg::*;

	localparam int QW = $bits(cls_t) + TIME_WIDTH;

	logic [BOUND_W-1:0]    lower_q;
	logic [BOUND_W-1:0]    upper_q;
	logic [DWELL_W-1:0]    dwell_q;

	fifo_stat_t            q_stat;
	logic                  push;
	logic                  pop;
	cls_t                  f_cls;
	logic [TIME_WIDTH-1:0] f_now;
	cls_t                  b_cls;
	logic [TIME_WIDTH-1:0] b_now;

	logic                  chk_rdy;
	logic                  chk_cmt;
	logic                  chk_run_side;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= LOWER_RST;
			upper_q <= UPPER_RST;
			dwell_q <= DWELL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOWER: lower_q <= cfg_wdata[BOUND_W-1:0];
				CFG_UPPER: upper_q <= cfg_wdata[BOUND_W-1:0];
				CFG_DWELL: dwell_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	ocov_front #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_front (
		.item       (item),
		.lower_bound(lower_q),
		.upper_bound(upper_q),
		.q_stat     (q_stat),
		.push       (push),
		.cls        (f_cls),
		.now        (f_now)
	);

	ocov_fifo #(
		.WIDTH(QW)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata ({f_cls, f_now}),
		.pop   (pop),
		.rdata ({b_cls, b_now}),
		.stat  (q_stat)
	);

	ocov_back #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_stat  (q_stat),
		.cls     (b_cls),
		.now     (b_now),
		.dwell_ms(dwell_q),
		.pop     (pop),
		.result  (result)
	);

	// result fields as the checks read them
	assign chk_rdy      = result.valid && result.ready_res;
	assign chk_cmt      = result.valid && result.side_committed;
	assign chk_run_side = result.progress[RUN_BIT] && (result.progress[SIDE_W-1:0] != '0);

	// ready only ever comes with every side covered and the run flag set
	`OCOV_ASSERT_IMP(a_ready_full, chk_rdy, result.progress == 8'hFF, "ready without full coverage")
	// a commit can only happen during a run and leaves at least one side
	`OCOV_ASSERT_IMP(a_commit_run, chk_cmt, chk_run_side, "commit outside a run")
	// a request taken into an empty queue leaves it non-empty
	`OCOV_ASSERT_NEXT(a_queue_fill, push && q_stat.empty, !q_stat.empty, "queued request lost")

endmodule

`default_nettype wire
